/* sv/ipp_pkg.sv */
// ipp_pkg: shared types, character codes and phase codes for the address text parser.
// No dependencies; imported by every module of the block.

package ipp_pkg;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_V4    = 3'd1;
    localparam logic [2:0] PH_LEAD  = 3'd2;
    localparam logic [2:0] PH_V6    = 3'd3;
    localparam logic [2:0] PH_UNSUP = 3'd4;

    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_MALFORMED   = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [4:0]  ADDR_BYTES = 5'd16;

    typedef struct packed {
        logic [1:0] family;
        logic [7:0] char_code;
    } ipp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
    } ipp_out_t;

    typedef struct packed {
        logic [15:0][7:0] addr_bytes;
        logic [4:0]       write_pos;
        logic [4:0]       gap_pos;
        logic             gap_seen;
        logic [15:0]      hex_accum;
        logic             saw_hex;
        logic [7:0]       dec_accum;
        logic [2:0]       octet_count;
        logic             saw_dec;
        logic             dotted_mode;
        logic [2:0]       parse_phase;
        logic             error_flag;
        logic             dec_void;
        logic             trail_colon;
    } ipp_state_t;

    typedef struct packed {
        logic       term;
        logic [2:0] phase;
    } ipp_step_t;

    typedef struct packed {
        logic             ok;
        logic [15:0][7:0] addr_bytes;
    } ipp_close_t;

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= CH_0 && ch <= CH_9)
        begin
            r = {1'b1, ch[3:0]};
        end
        else if (ch >= CH_LA && ch <= CH_LF)
        begin
            r = {1'b1, 4'(ch - CH_LA + 8'd10)};
        end
        else if (ch >= CH_UA && ch <= CH_UF)
        begin
            r = {1'b1, 4'(ch - CH_UA + 8'd10)};
        end
        return r;
    endfunction

endpackage

/* sv/ipp_step.sv */
// ipp_step: next parser state for one character item.
// Depends on ipp_pkg.

module ipp_step
    import ipp_pkg::*;
(
    input  ipp_state_t cur,
    input  ipp_in_t    item,
    output ipp_state_t nxt,
    output ipp_step_t  info
);

    logic [7:0]  ch;
    logic [4:0]  hx;
    logic [3:0]  hv;
    logic        is_dig;
    logic        is_hex;
    logic [2:0]  phase_eff;
    logic        term;
    logic        lead_colon;
    logic [11:0] dec_n;
    logic [2:0]  new_oc;
    logic [4:0]  base;
    logic        dd_fail;
    logic        ds_fail;
    logic [3:0]  dd_idx;
    logic        fail;
    logic        v6_run;
    logic        we0;
    logic        we1;
    logic [3:0]  wa0;
    logic [3:0]  wa1;
    logic [7:0]  wd0;
    logic [7:0]  wd1;

    always_comb
    begin
        ch     = item.char_code;
        hx     = hex_value(ch);
        is_hex = hx[4];
        hv     = hx[3:0];
        is_dig = (ch >= CH_0) && (ch <= CH_9);
        term   = (ch == CH_NUL);

        lead_colon = 1'b0;
        phase_eff  = cur.parse_phase;
        if (cur.parse_phase == PH_START)
        begin
            if (item.family == FAM_IPV4)
            begin
                phase_eff = PH_V4;
            end
            else if (item.family == FAM_IPV6)
            begin
                phase_eff  = PH_V6;
                lead_colon = (ch == CH_COLON);
            end
            else
            begin
                phase_eff = PH_UNSUP;
            end
        end

        dec_n   = 12'(cur.dec_accum) * 12'd10 + 12'(hv);
        new_oc  = cur.saw_dec ? cur.octet_count : cur.octet_count + 3'd1;
        base    = (phase_eff == PH_V4) ? 5'd0 : cur.write_pos;
        dd_fail = (cur.saw_dec && cur.dec_accum == 8'd0) || (dec_n > OCTET_MAX)
                  || (!cur.saw_dec && new_oc > 3'd4);
        ds_fail = !cur.saw_dec || (cur.octet_count == 3'd4);
        dd_idx  = 4'(base + 5'(new_oc) - 5'd1);
        v6_run  = (phase_eff == PH_V6) || (phase_eff == PH_LEAD && ch == CH_COLON);

        nxt  = cur;
        fail = 1'b0;
        we0  = 1'b0;
        we1  = 1'b0;
        wa0  = 4'd0;
        wa1  = 4'd0;
        wd0  = 8'd0;
        wd1  = 8'd0;

        if (term)
        begin
            nxt             = '0;
            nxt.parse_phase = PH_START;
        end
        else if (lead_colon)
        begin
            nxt.parse_phase = PH_LEAD;
        end
        else
        begin
            nxt.parse_phase = phase_eff;
            if (!cur.error_flag && phase_eff != PH_UNSUP)
            begin
                if (phase_eff == PH_V4 || (v6_run && cur.dotted_mode))
                begin
                    if (is_dig)
                    begin
                        if (dd_fail)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            nxt.dec_accum   = dec_n[7:0];
                            nxt.octet_count = new_oc;
                            nxt.saw_dec     = 1'b1;
                            we0             = 1'b1;
                            wa0             = dd_idx;
                            wd0             = dec_n[7:0];
                        end
                    end
                    else if (ch == CH_DOT)
                    begin
                        if (ds_fail)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            nxt.dec_accum = 8'd0;
                            nxt.saw_dec   = 1'b0;
                        end
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                else if (v6_run)
                begin
                    nxt.parse_phase = PH_V6;
                    if (is_hex)
                    begin
                        if (cur.hex_accum[15:12] != 4'd0)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            nxt.hex_accum   = {cur.hex_accum[11:0], hv};
                            nxt.saw_hex     = 1'b1;
                            nxt.trail_colon = 1'b0;
                            if (!cur.dec_void)
                            begin
                                if (hv > 4'd9 || (cur.saw_dec && cur.dec_accum == 8'd0)
                                    || dec_n > OCTET_MAX)
                                begin
                                    nxt.dec_void = 1'b1;
                                end
                                else
                                begin
                                    nxt.dec_accum = dec_n[7:0];
                                    nxt.saw_dec   = 1'b1;
                                end
                            end
                        end
                    end
                    else if (ch == CH_COLON)
                    begin
                        nxt.trail_colon = 1'b0;
                        nxt.dec_accum   = 8'd0;
                        nxt.saw_dec     = 1'b0;
                        nxt.dec_void    = 1'b0;
                        if (!cur.saw_hex)
                        begin
                            if (cur.gap_seen)
                            begin
                                fail = 1'b1;
                            end
                            else
                            begin
                                nxt.gap_seen = 1'b1;
                                nxt.gap_pos  = cur.write_pos;
                            end
                        end
                        else if (cur.write_pos > 5'd14)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            we0             = 1'b1;
                            wa0             = cur.write_pos[3:0];
                            wd0             = cur.hex_accum[15:8];
                            we1             = 1'b1;
                            wa1             = cur.write_pos[3:0] + 4'd1;
                            wd1             = cur.hex_accum[7:0];
                            nxt.write_pos   = cur.write_pos + 5'd2;
                            nxt.saw_hex     = 1'b0;
                            nxt.hex_accum   = 16'd0;
                            nxt.trail_colon = 1'b1;
                        end
                    end
                    else if (ch == CH_DOT)
                    begin
                        if (cur.write_pos > 5'd12 || cur.dec_void || !cur.saw_dec)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            we0             = 1'b1;
                            wa0             = cur.write_pos[3:0];
                            wd0             = cur.dec_accum;
                            nxt.octet_count = 3'd1;
                            nxt.dec_accum   = 8'd0;
                            nxt.saw_dec     = 1'b0;
                            nxt.saw_hex     = 1'b0;
                            nxt.hex_accum   = 16'd0;
                            nxt.dotted_mode = 1'b1;
                        end
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                else
                begin
                    fail = 1'b1;
                end
                if (fail)
                begin
                    nxt.error_flag = 1'b1;
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                if (we0 && wa0 == 4'(i))
                begin
                    nxt.addr_bytes[i] = wd0;
                end
                else if (we1 && wa1 == 4'(i))
                begin
                    nxt.addr_bytes[i] = wd1;
                end
            end
        end

        info.term  = term;
        info.phase = phase_eff;
    end

endmodule

/* sv/ipp_close.sv */
// ipp_close: end-of-string check and gap expansion of an IPv6 address.
// Depends on ipp_pkg.

module ipp_close
    import ipp_pkg::*;
(
    input  ipp_state_t cur,
    output ipp_close_t res
);

    logic             fail;
    logic [4:0]       wp2;
    logic [4:0]       shift;
    logic [4:0]       src;
    logic [15:0][7:0] b2;

    always_comb
    begin
        fail = 1'b0;
        b2   = cur.addr_bytes;
        wp2  = cur.write_pos;
        if (cur.dotted_mode)
        begin
            fail = (cur.octet_count != 3'd4);
            wp2  = cur.write_pos + 5'd4;
        end
        else
        begin
            if (cur.trail_colon)
            begin
                fail = 1'b1;
            end
            if (cur.saw_hex)
            begin
                if (cur.write_pos > 5'd14)
                begin
                    fail = 1'b1;
                end
                b2[cur.write_pos[3:0]]        = cur.hex_accum[15:8];
                b2[cur.write_pos[3:0] + 4'd1] = cur.hex_accum[7:0];
                wp2                           = cur.write_pos + 5'd2;
            end
        end

        shift          = ADDR_BYTES - wp2;
        res.addr_bytes = b2;
        if (cur.gap_seen)
        begin
            if (wp2 >= ADDR_BYTES || cur.gap_pos > wp2)
            begin
                fail = 1'b1;
            end
            for (int j = 0; j < 16; j++)
            begin
                src = 5'(j) - shift;
                if (5'(j) < cur.gap_pos)
                begin
                    res.addr_bytes[j] = b2[j];
                end
                else if (5'(j) < cur.gap_pos + shift)
                begin
                    res.addr_bytes[j] = 8'd0;
                end
                else
                begin
                    res.addr_bytes[j] = b2[src[3:0]];
                end
            end
            res.ok = !fail;
        end
        else
        begin
            src    = 5'd0;
            res.ok = !fail && (wp2 == ADDR_BYTES);
        end
    end

endmodule

/* sv/ip_address_text_parser.sv */
// ip_address_text_parser: character-serial IPv4 / IPv6 address text parser, top level.
// Depends on ipp_pkg, ipp_step and ipp_close.
//
//  channel   direction  handshake                    payload
//  char      in         char_valid / char_stall      char_item   (ipp_in_t)
//  result    out        result_valid / result_stall  result_item (ipp_out_t)
//
// One character item per cycle while char_stall is low; the parse state updates at the accepting edge.
// A terminator loads the result register, visible the next cycle.
// char_stall follows only a stalled held result; reset clears all but result_reg.
// No result comes out for characters other than the terminator.

module ip_address_text_parser
    import ipp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     char_valid,
    output logic     char_stall,
    input  ipp_in_t  char_item,
    output logic     result_valid,
    input  logic     result_stall,
    output ipp_out_t result_item
);

    ipp_state_t state_reg;
    ipp_state_t state_next;
    ipp_step_t  info;
    ipp_close_t close_res;
    logic       result_valid_reg;
    logic       result_valid_next;
    ipp_out_t   result_reg;
    ipp_out_t   result_next;
    logic       accept;

    ipp_step u_step (
        .cur  (state_reg),
        .item (char_item),
        .nxt  (state_next),
        .info (info)
    );

    ipp_close u_close (
        .cur (state_reg),
        .res (close_res)
    );

    assign char_stall = result_valid_reg && result_stall;
    assign accept     = char_valid && !char_stall;

    always_comb
    begin
        result_next = '{status: ST_MALFORMED, addr_hi: 64'd0, addr_lo: 64'd0};
        case (info.phase)
            PH_UNSUP:
            begin
                result_next.status = ST_UNSUPPORTED;
            end
            PH_V4:
            begin
                if (!state_reg.error_flag && state_reg.octet_count == 3'd4)
                begin
                    result_next.status  = ST_OK;
                    result_next.addr_lo = {32'd0, state_reg.addr_bytes[0],
                                           state_reg.addr_bytes[1],
                                           state_reg.addr_bytes[2],
                                           state_reg.addr_bytes[3]};
                end
            end
            PH_V6:
            begin
                if (!state_reg.error_flag && close_res.ok)
                begin
                    result_next.status = ST_OK;
                    for (int i = 0; i < 8; i++)
                    begin
                        result_next.addr_hi[63 - 8 * i -: 8] = close_res.addr_bytes[i];
                        result_next.addr_lo[63 - 8 * i -: 8] = close_res.addr_bytes[i + 8];
                    end
                end
            end
            default:
            begin
                result_next.status = ST_MALFORMED;
            end
        endcase

        if (accept && info.term)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    // all-zero state is PH_START with a cleared string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && info.term)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule

/* tb/ipp_parse_checker.sv */
`timescale 1ns / 100ps
// ipp_parse_checker: watches the character and result channels of the address text parser,
// predicts each result from the accepted characters and compares field by field.
// Depends on ipp_pkg.

module ipp_parse_checker
    import ipp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     char_valid,
    input  logic     char_stall,
    input  ipp_in_t  char_item,
    input  logic     result_valid,
    input  logic     result_stall,
    input  ipp_out_t result_item,
    output int       fails,
    output int       pending,
    output int       checked,
    output int       ok_count
);

    logic [7:0]  abuf [16];
    int unsigned wr_at, gap_at, hex_acc, dec_acc, oct_n;
    logic [2:0]  phase;
    bit          gap_on, hex_any, dec_any, in_tail, failed, dec_bad, colon_end;

    ipp_out_t    want_addr_q [$];
    int          err_n = 0;
    int          chk_n = 0;
    int          ok_n  = 0;

    function automatic void clear_text();
        foreach (abuf[i])
            abuf[i] = 8'h00;
        wr_at     = 0;
        gap_at    = 0;
        hex_acc   = 0;
        dec_acc   = 0;
        oct_n     = 0;
        gap_on    = 1'b0;
        hex_any   = 1'b0;
        dec_any   = 1'b0;
        in_tail   = 1'b0;
        failed    = 1'b0;
        dec_bad   = 1'b0;
        colon_end = 1'b0;
        phase     = PH_START;
    endfunction

    function automatic int nibble_of(input logic [7:0] ch);
        if (ch >= CH_0 && ch <= CH_9)
            return int'(ch - CH_0);
        if (ch >= CH_LA && ch <= CH_LF)
            return int'(ch - CH_LA) + 10;
        if (ch >= CH_UA && ch <= CH_UF)
            return int'(ch - CH_UA) + 10;
        return -1;
    endfunction

    // decimal digit of a dotted octet, stored at base + octet index
    function automatic bit octet_digit(input int unsigned d, input int unsigned base);
        int unsigned n;
        if (dec_any && dec_acc == 0)
            return 1'b0;
        n = dec_acc * 10 + d;
        if (n > 255)
            return 1'b0;
        dec_acc = n;
        if (!dec_any)
        begin
            oct_n++;
            if (oct_n > 4)
                return 1'b0;
            dec_any = 1'b1;
        end
        abuf[(base + oct_n - 1) & 15] = 8'(dec_acc);
        return 1'b1;
    endfunction

    function automatic bit octet_dot();
        if (!dec_any || oct_n == 4)
            return 1'b0;
        dec_acc = 0;
        dec_any = 1'b0;
        return 1'b1;
    endfunction

    function automatic void push_group();
        abuf[wr_at & 15]       = 8'(hex_acc >> 8);
        abuf[(wr_at + 1) & 15] = 8'(hex_acc);
        wr_at += 2;
    endfunction

    function automatic bit v6_step(input logic [7:0] ch);
        int          hv;
        int unsigned d, v, n;
        if (in_tail)
        begin
            if (ch >= CH_0 && ch <= CH_9)
                return octet_digit(int'(ch - CH_0), wr_at);
            if (ch == CH_DOT)
                return octet_dot();
            return 1'b0;
        end
        hv = nibble_of(ch);
        if (hv >= 0)
        begin
            d = hv;
            v = (hex_acc << 4) | d;
            if (v > 32'hffff)
                return 1'b0;
            hex_acc   = v;
            hex_any   = 1'b1;
            colon_end = 1'b0;
            if (!dec_bad)
            begin
                if (d > 9 || (dec_any && dec_acc == 0))
                begin
                    dec_bad = 1'b1;
                end
                else
                begin
                    n = dec_acc * 10 + d;
                    if (n > 255)
                    begin
                        dec_bad = 1'b1;
                    end
                    else
                    begin
                        dec_acc = n;
                        dec_any = 1'b1;
                    end
                end
            end
            return 1'b1;
        end
        if (ch == CH_COLON)
        begin
            colon_end = 1'b0;
            dec_acc   = 0;
            dec_any   = 1'b0;
            dec_bad   = 1'b0;
            if (!hex_any)
            begin
                if (gap_on)
                    return 1'b0;
                gap_on = 1'b1;
                gap_at = wr_at;
                return 1'b1;
            end
            if (wr_at > 14)
                return 1'b0;
            push_group();
            hex_any   = 1'b0;
            hex_acc   = 0;
            colon_end = 1'b1;
            return 1'b1;
        end
        if (ch == CH_DOT)
        begin
            if (wr_at > 12 || dec_bad || !dec_any)
                return 1'b0;
            abuf[wr_at & 15] = 8'(dec_acc);
            oct_n   = 1;
            dec_acc = 0;
            dec_any = 1'b0;
            hex_any = 1'b0;
            hex_acc = 0;
            in_tail = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // closes the last group or dotted tail and expands the gap to the end
    function automatic bit v6_finish();
        int unsigned n, src;
        if (in_tail)
        begin
            if (oct_n != 4)
                return 1'b0;
            wr_at += 4;
        end
        else
        begin
            if (colon_end)
                return 1'b0;
            if (hex_any)
            begin
                if (wr_at > 14)
                    return 1'b0;
                push_group();
            end
        end
        if (gap_on)
        begin
            if (wr_at >= 16 || gap_at > wr_at)
                return 1'b0;
            n = wr_at - gap_at;
            for (int unsigned i = 1; i <= n; i++)
            begin
                src = (gap_at + n - i) & 15;
                abuf[(16 - i) & 15] = abuf[src];
                abuf[src] = 8'h00;
            end
            wr_at = 16;
        end
        return wr_at == 16;
    endfunction

    function automatic ipp_out_t address_verdict();
        ipp_out_t r;
        r = '0;
        r.status = ST_MALFORMED;
        if (phase == PH_UNSUP)
        begin
            r.status = ST_UNSUPPORTED;
        end
        else if (phase == PH_V4)
        begin
            if (!failed && oct_n == 4)
            begin
                r.status  = ST_OK;
                r.addr_lo = {32'h0, abuf[0], abuf[1], abuf[2], abuf[3]};
            end
        end
        else if (phase == PH_V6)
        begin
            if (!failed && v6_finish())
            begin
                r.status = ST_OK;
                for (int i = 0; i < 8; i++)
                begin
                    r.addr_hi = {r.addr_hi[55:0], abuf[i]};
                    r.addr_lo = {r.addr_lo[55:0], abuf[i + 8]};
                end
            end
        end
        return r;
    endfunction

    // advances the parse by one character; returns 1 when a result is due
    function automatic bit parse_char(input ipp_in_t it, output ipp_out_t res);
        bit ok;
        ok  = 1'b1;
        res = '0;
        if (phase == PH_START)
        begin
            clear_text();
            if (it.family == FAM_IPV4)
            begin
                phase = PH_V4;
            end
            else if (it.family == FAM_IPV6)
            begin
                if (it.char_code == CH_COLON)
                begin
                    phase = PH_LEAD;
                    return 1'b0;
                end
                phase = PH_V6;
            end
            else
            begin
                phase = PH_UNSUP;
            end
        end
        if (it.char_code == CH_NUL)
        begin
            res = address_verdict();
            clear_text();
            return 1'b1;
        end
        if (failed || phase == PH_UNSUP)
            return 1'b0;
        if (phase == PH_V4)
        begin
            if (it.char_code >= CH_0 && it.char_code <= CH_9)
                ok = octet_digit(int'(it.char_code - CH_0), 0);
            else if (it.char_code == CH_DOT)
                ok = octet_dot();
            else
                ok = 1'b0;
        end
        else if (phase == PH_LEAD)
        begin
            if (it.char_code == CH_COLON)
            begin
                phase = PH_V6;
                ok = v6_step(it.char_code);
            end
            else
            begin
                ok = 1'b0;
            end
        end
        else
        begin
            ok = v6_step(it.char_code);
        end
        if (!ok)
            failed = 1'b1;
        return 1'b0;
    endfunction

    task automatic mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
        err_n++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ipp_out_t want;
        ipp_out_t pred;
        if (!rst_n)
        begin
            want_addr_q.delete();
            clear_text();
            pending  <= 0;
            fails    <= err_n;
            checked  <= chk_n;
            ok_count <= ok_n;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (want_addr_q.size() == 0)
                begin
                    mismatch("result with none pending, addr_lo", result_item.addr_lo, 64'h0);
                end
                else
                begin
                    want = want_addr_q.pop_front();
                    chk_n++;
                    if (want.status == ST_OK)
                        ok_n++;
                    if (result_item.status !== want.status)
                        mismatch("status", 64'(result_item.status), 64'(want.status));
                    if (result_item.addr_hi !== want.addr_hi)
                        mismatch("addr_hi", result_item.addr_hi, want.addr_hi);
                    if (result_item.addr_lo !== want.addr_lo)
                        mismatch("addr_lo", result_item.addr_lo, want.addr_lo);
                end
            end
            if (char_valid && !char_stall)
            begin
                if (parse_char(char_item, pred))
                    want_addr_q.push_back(pred);
            end
            pending  <= want_addr_q.size();
            fails    <= err_n;
            checked  <= chk_n;
            ok_count <= ok_n;
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: top of the address text parser testbench; drives character strings and stalls,
// and gives the verdict. Depends on ipp_pkg, ip_address_text_parser and ipp_parse_checker.

module tb;
    import ipp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_CHARS    = 283;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     char_valid   = 1'b0;
    logic     char_stall;
    ipp_in_t  char_item    = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    ipp_out_t result_item;

    int       fails, pending, checked, ok_count;
    int       src_gap_pct    = 0;
    int       sink_stall_pct = 0;
    int       chars_sent     = 0;
    int       strings_sent   = 0;
    int       idle_cycles    = 0;
    logic [7:0] text_q [$];

    ip_address_text_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    ipp_parse_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .fails        (fails),
        .pending      (pending),
        .checked      (checked),
        .ok_count     (ok_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_char(input logic [1:0] fam, input logic [7:0] ch);
        while ($urandom_range(99) < src_gap_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= {fam, ch};
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        chars_sent++;
    endtask

    // family only counts on the first item; later items carry random noise there
    task automatic send_string(input logic [1:0] fam);
        foreach (text_q[i])
            send_char((i == 0) ? fam : 2'($urandom_range(3)), text_q[i]);
        send_char((text_q.size() == 0) ? fam : 2'($urandom_range(3)), CH_NUL);
        strings_sent++;
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input int nib);
        if (nib < 10)
            return CH_0 + 8'(nib);
        return (($urandom_range(1) != 0) ? CH_UA : CH_LA) + 8'(nib - 10);
    endfunction

    function automatic logic [7:0] pick_char();
        int k;
        k = $urandom_range(23);
        if (k < 16)
            return hex_char(k);
        if (k < 22)
            return CH_UA + 8'(k - 16);
        if (k == 22)
            return CH_COLON;
        return CH_DOT;
    endfunction

    function automatic void put_dec(input int v);
        if (v >= 100)
            text_q.push_back(CH_0 + 8'(v / 100));
        if (v >= 10)
            text_q.push_back(CH_0 + 8'((v / 10) % 10));
        text_q.push_back(CH_0 + 8'(v % 10));
    endfunction

    function automatic void put_octet();
        int r;
        r = $urandom_range(99);
        if ($urandom_range(99) < 4)
            text_q.push_back(CH_0);
        if (r < 10)
            put_dec(255);
        else if (r < 20)
            put_dec(0);
        else if (r < 25)
            put_dec($urandom_range(999, 256));
        else
            put_dec($urandom_range(255));
    endfunction

    function automatic void put_group();
        int  n;
        bit  dec_only, all_f;
        n = $urandom_range(4, 1);
        if ($urandom_range(99) < 3)
            n = 5;
        dec_only = ($urandom_range(99) < 30);
        all_f    = ($urandom_range(99) < 5);
        for (int i = 0; i < n; i++)
            text_q.push_back(hex_char(all_f ? 15 : dec_only ? $urandom_range(9)
                                                            : $urandom_range(15)));
    endfunction

    function automatic void make_ipv4();
        int n;
        n = ($urandom_range(99) < 85) ? 4 : $urandom_range(5, 3);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                text_q.push_back(CH_DOT);
            put_octet();
        end
    endfunction

    function automatic void make_ipv6();
        int left, right, total, used;
        bit gap, tail;
        tail  = ($urandom_range(99) < 25);
        gap   = ($urandom_range(99) < 45);
        total = tail ? 6 : 8;
        right = 0;
        left  = total;
        if (gap)
        begin
            used  = $urandom_range(total - 1);
            left  = $urandom_range(used);
            right = used - left;
        end
        if ($urandom_range(99) < 10)
            left++;
        for (int i = 0; i < left; i++)
        begin
            if (i > 0)
                text_q.push_back(CH_COLON);
            put_group();
        end
        if (gap)
        begin
            text_q.push_back(CH_COLON);
            text_q.push_back(CH_COLON);
        end
        for (int i = 0; i < right; i++)
        begin
            if (i > 0)
                text_q.push_back(CH_COLON);
            put_group();
        end
        if (tail)
        begin
            if ((!gap && left > 0) || (gap && right > 0))
                text_q.push_back(CH_COLON);
            make_ipv4();
        end
    endfunction

    function automatic void make_noise();
        int n;
        n = $urandom_range(10);
        for (int i = 0; i < n; i++)
            text_q.push_back(($urandom_range(99) < 70) ? pick_char() : 8'($urandom_range(255, 1)));
    endfunction

    function automatic void mutate_text();
        int pos;
        logic [7:0] ch;
        ch = ($urandom_range(1) != 0) ? pick_char() : 8'($urandom_range(255, 1));
        if (text_q.size() == 0)
        begin
            text_q.push_back(ch);
            return;
        end
        pos = $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
            0: text_q[pos] = ch;
            1: text_q.insert(pos, ch);
            default: text_q.delete(pos);
        endcase
    endfunction

    task automatic send_random_string();
        int r;
        logic [1:0] fam;
        r = $urandom_range(99);
        text_q.delete();
        if (r < 35)
        begin
            make_ipv4();
            fam = FAM_IPV4;
        end
        else if (r < 75)
        begin
            make_ipv6();
            fam = FAM_IPV6;
        end
        else if (r < 92)
        begin
            make_noise();
            fam = 2'($urandom_range(1));
        end
        else
        begin
            make_noise();
            fam = 2'($urandom_range(3, 2));
        end
        if (r < 75 && $urandom_range(99) < 20)
            mutate_text();
        if (r < 75 && $urandom_range(99) < 4)
            fam = fam ^ 2'd1;
        send_string(fam);
    endtask

    initial
    begin
        int base;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty strings per family, unsupported family, limits and high bytes
        text_q.delete();
        send_string(FAM_IPV4);
        send_string(FAM_IPV6);
        send_string(2'd2);
        text_q.push_back(8'hff);
        send_string(2'd3);
        load_text("255.0.0.9");
        send_string(FAM_IPV4);
        text_q.delete();
        text_q.push_back(8'h80);
        send_string(FAM_IPV4);
        load_text("::");
        send_string(FAM_IPV6);
        load_text(":1");
        send_string(FAM_IPV6);

        base = chars_sent;
        for (int ph = 0; ph < 3; ph++)
        begin
            src_gap_pct    = (ph == 0) ? 8 : (ph == 1) ? 79 : 0;
            sink_stall_pct = (ph == 0) ? 79 : (ph == 1) ? 8 : 0;
            while (chars_sent < base + PHASE_CHARS * (ph + 1))
                send_random_string();
        end

        char_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d strings as %0d characters over three stall mixes", strings_sent,
                 chars_sent);
        $display("Compared %0d results, %0d of them parsed addresses", checked, ok_count);
        if (fails == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
